// ----- rtl/core/r2a_pkg.sv -----
// Shared constants, types and helper functions for the radix-to-ASCII converter.
package r2a_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 7;
    localparam int DIV_STEP       = 8;
    localparam int FIFO_DEPTH     = 2;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT   = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
    localparam logic [CHAR_W-1:0] DEC_OFFSET = 7'd10;

    // register index, taken from paddr[2]
    localparam logic REG_RADIX = 1'b0;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic [DIGIT_W-1:0] clamp_radix(input logic [DIGIT_W-1:0] r);
        logic [DIGIT_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d >= DEC_LIMIT)
        begin
            res = ASCII_A + {1'b0, d} - DEC_OFFSET;
        end
        else
        begin
            res = ASCII_ZERO + {1'b0, d};
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/radix_to_ascii_converter_top.sv -----
// Top level of the radix-to-ASCII converter: APB register, front, queue, back and digit RAM.
//
//  channel | signals                                  | dir | word
//  value   | value, value_valid, value_stall          | in  | one integer
//  char    | character, final_res, char_valid/stall   | out | one ASCII digit
//  apb     | psel, penable, pwrite, paddr, pwdata ... | in  | radix register
//
// In the back part the divider retires 8 quotient bits per cycle, and each digit
// is emitted through a read state and a load state, since the RAM read is registered.
// No clearing pass after reset.
// The front takes a new word while the queue has room; a stalled output holds
// the back part in its emit step.
module radix_to_ascii_converter_top #(
    parameter int VALUE_BITS = r2a_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [VALUE_BITS-1:0]         value,
    input  logic                          value_valid,
    output logic                          value_stall,
    output logic [r2a_pkg::CHAR_W-1:0]    character,
    output logic                          final_res,
    output logic                          char_valid,
    input  logic                          char_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [r2a_pkg::PADDR_W-1:0]   paddr,
    input  logic [r2a_pkg::PDATA_W-1:0]   pwdata,
    output logic [r2a_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import r2a_pkg::*;

    localparam int QW = VALUE_BITS + DIGIT_W;
    localparam int AW = $clog2(VALUE_BITS);

    logic [DIGIT_W-1:0]    radix_reg;
    logic                  cfg_wr;

    q_stat_t               q_stat;
    logic                  q_push, q_pop;
    logic [VALUE_BITS-1:0] front_value, q_value;
    logic [DIGIT_W-1:0]    front_base, q_base;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DIGIT_W-1:0]    ram_wdata, ram_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIX);
    assign prdata = (paddr[2] == REG_RADIX) ? PDATA_W'(radix_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_wr)
        begin
            radix_reg <= pwdata[DIGIT_W-1:0];
        end
    end

    r2a_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .radix       (radix_reg),
        .q_stat      (q_stat),
        .push        (q_push),
        .push_value  (front_value),
        .push_base   (front_base)
    );

    r2a_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({front_value, front_base}),
        .pop   (q_pop),
        .rdata ({q_value, q_base}),
        .stat  (q_stat)
    );

    r2a_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_digit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    r2a_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .pop_value  (q_value),
        .pop_base   (q_base),
        .pop        (q_pop),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .character  (character),
        .final_res  (final_res),
        .char_valid (char_valid),
        .char_stall (char_stall)
    );

`ifndef SYNTH
    ast_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    ast_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    ast_ram_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("digit RAM written and read in the same cycle");

    ast_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> ((character >= 7'd48 && character <= 7'd57) ||
                        (character >= 7'd65 && character <= 7'd90)))
        else $error("output word is not a digit character");
`endif

endmodule

// ----- rtl/core/r2a_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module r2a_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 31
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/r2a_fifo.sv -----
// Small register queue between the front and back parts.
module r2a_fifo #(
    parameter int WIDTH = 37,
    parameter int DEPTH = r2a_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output r2a_pkg::q_stat_t stat
);
    import r2a_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata      = entry_reg[rd_ptr_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CW'(DEPTH));

endmodule

// ----- rtl/core/r2a_front.sv -----
// Input stage: takes a word, clamps the radix and hands both to the queue.
module r2a_front #(
    parameter int VALUE_BITS = r2a_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [VALUE_BITS-1:0]         value,
    input  logic                          value_valid,
    output logic                          value_stall,
    input  logic [r2a_pkg::DIGIT_W-1:0]   radix,
    input  r2a_pkg::q_stat_t              q_stat,
    output logic                          push,
    output logic [VALUE_BITS-1:0]         push_value,
    output logic [r2a_pkg::DIGIT_W-1:0]   push_base
);
    import r2a_pkg::*;

    logic                  valid_reg, valid_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [DIGIT_W-1:0]    base_reg;
    logic                  accept;

    assign push        = valid_reg && !q_stat.full;
    assign value_stall = valid_reg && q_stat.full;
    assign accept      = value_valid && !value_stall;
    assign valid_next  = accept || (valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value;
            base_reg  <= clamp_radix(radix);
        end
    end

    assign push_value = value_reg;
    assign push_base  = base_reg;

endmodule

// ----- rtl/core/r2a_back.sv -----
// Conversion engine: digit-by-digit division into the digit RAM, then emission MSD first.
module r2a_back #(
    parameter int VALUE_BITS = r2a_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  r2a_pkg::q_stat_t                  q_stat,
    input  logic [VALUE_BITS-1:0]             pop_value,
    input  logic [r2a_pkg::DIGIT_W-1:0]       pop_base,
    output logic                              pop,
    output logic                              ram_we,
    output logic [$clog2(VALUE_BITS)-1:0]     ram_waddr,
    output logic [r2a_pkg::DIGIT_W-1:0]       ram_wdata,
    output logic                              ram_re,
    output logic [$clog2(VALUE_BITS)-1:0]     ram_raddr,
    input  logic [r2a_pkg::DIGIT_W-1:0]       ram_rdata,
    output logic [r2a_pkg::CHAR_W-1:0]        character,
    output logic                              final_res,
    output logic                              char_valid,
    input  logic                              char_stall
);
    import r2a_pkg::*;

    localparam int CYC   = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD_W = CYC * DIV_STEP;
    localparam int CYC_W = (CYC > 1) ? $clog2(CYC) : 1;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int AW    = $clog2(VALUE_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_LD   = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [PAD_W-1:0]   work_reg, work_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [DIGIT_W-1:0] base_reg, base_next;
    logic [CYC_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               final_reg, final_next;

    logic [DIGIT_W-1:0] div_rem;
    logic [PAD_W-1:0]   div_work;

    // DIV_STEP restoring-division steps per cycle on a narrow remainder
    always_comb
    begin
        logic [DIGIT_W:0]   t;
        logic [DIGIT_W-1:0] r;
        logic [PAD_W-1:0]   w;
        r = rem_reg;
        w = work_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            t = {r, w[PAD_W-1]};
            w = {w[PAD_W-2:0], 1'b0};
            if (t >= {1'b0, base_reg})
            begin
                r    = DIGIT_W'(t - {1'b0, base_reg});
                w[0] = 1'b1;
            end
            else
            begin
                r = t[DIGIT_W-1:0];
            end
        end
        div_rem  = r;
        div_work = w;
    end

    always_comb
    begin
        logic out_free;
        state_next     = state_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        base_next      = base_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        char_next      = char_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg && char_stall;
        out_free       = !out_valid_reg || !char_stall;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = div_rem;
        ram_re         = 1'b0;
        ram_raddr      = rd_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    work_next  = PAD_W'(pop_value);
                    base_next  = pop_base;
                    rem_next   = '0;
                    step_next  = '0;
                    count_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                work_next = div_work;
                rem_next  = div_rem;
                step_next = step_reg + 1'b1;
                if (step_reg == CYC_W'(CYC - 1))
                begin
                    // one digit done; a zero quotient ends the number
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    rem_next   = '0;
                    step_next  = '0;
                    if (div_work == '0)
                    begin
                        rd_idx_next = count_reg[AW-1:0];
                        state_next  = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_LD;
            end
            ST_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char(ram_rdata);
                    final_next     = (rd_idx_reg == '0);
                    if (rd_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            work_reg      <= '0;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            work_reg      <= work_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        base_reg   <= base_next;
        rd_idx_reg <= rd_idx_next;
        char_reg   <= char_next;
        final_reg  <= final_next;
    end

    assign character  = char_reg;
    assign final_res  = final_reg;
    assign char_valid = out_valid_reg;

endmodule
